/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with reset masking, used by the top-level RTL file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk while rst_n is high.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that expr is never true at a rising edge of clk while rst_n is high.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	`ASSERT_PROP(label, clk, rst_n, !(expr), msg)

`endif

/* hw/rtl/dzc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Dead-zone response curve package
// Widths, register indexes, zone codes and the types shared by the block.
// ---------------------------------------------------------------------------
package dzc_pkg;

	localparam int FRAC_BITS = 8;

	localparam int AXIS_W     = 16;
	localparam int DRIVE_W    = 18;
	localparam int ZONE_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int POS_W      = 15;
	localparam int LVL_W      = 16;
	localparam int DEN_W      = POS_W + FRAC_BITS;
	localparam int NUM_W      = 40;
	localparam int DISC_W     = 35;
	localparam int ROOT_W     = 16;
	localparam int QUOT_W     = 18;
	localparam int T_W        = 17;
	localparam int LVL_SHIFT  = 32 + FRAC_BITS;

	localparam logic [POS_W-1:0] FULL_SCALE = POS_W'(100 << FRAC_BITS);
	localparam logic [T_W-1:0]   T_ONE      = T_W'(1 << 16);
	localparam logic [16:0]      DRIVE_MAX  = 17'h1FFFF;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [CFG_IDX_W-1:0] REG_CURVE_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BEND_X     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BEND_Y     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL  = 3'd4;

	localparam logic [POS_W-1:0] RST_DEAD_ZONE = 15'd0;
	localparam logic [POS_W-1:0] RST_BEND_X    = 15'd12800;
	localparam logic [LVL_W-1:0] RST_BEND_Y    = 16'd12800;
	localparam logic [LVL_W-1:0] RST_MAX_LEVEL = 16'd25600;

	typedef enum logic [ZONE_W-1:0] {
		ZONE_DEAD,
		ZONE_ACTIVE,
		ZONE_OVER,
		ZONE_FAULT
	} zone_t;

	typedef struct packed {
		logic             curve_mode;
		logic [POS_W-1:0] dead_zone;
		logic [POS_W-1:0] bend_x;
		logic [LVL_W-1:0] bend_y;
		logic [LVL_W-1:0] max_level;
	} cfg_t;

	typedef struct packed {
		logic                     neg;
		zone_t                    zone;
		logic                     bez;
		logic                     degen;
		logic signed [DISC_W-1:0] disc;
		logic signed [17:0]       base;
		logic signed [17:0]       dval;
		logic [NUM_W-1:0]         lin_num;
		logic [DEN_W-1:0]         lin_den;
	} fe_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* hw/rtl/dzc_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Dead-zone response curve front end
// Takes axis samples, sorts them into zones and forms the curve terms.
// ---------------------------------------------------------------------------
module dzc_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dzc_pkg::cfg_t                     cfg,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [dzc_pkg::AXIS_W-1:0] axis_value,
	output logic                              item_valid,
	output dzc_pkg::fe_item_t                 item,
	input  dzc_pkg::q_stat_t                  q_stat
);
	import dzc_pkg::*;

	logic                     adv;
	logic [AXIS_W-1:0]        a_u;
	logic [AXIS_W-1:0]        mag_x;
	logic signed [17:0]       d_full;
	logic signed [17:0]       x2_m_x1;
	logic signed [17:0]       x_m_x1;
	logic signed [DISC_W-1:0] xd_c;
	zone_t                    zone_c;

	logic                     vld_s1;
	logic                     neg_s1;
	zone_t                    zone_s1;
	logic                     bez_s1;
	logic                     degen_s1;
	logic signed [DISC_W-1:0] xd_s1;
	logic [29:0]              x2sq_s1;
	logic [29:0]              x1h_s1;
	logic [31:0]              lin_prod_s1;
	logic signed [17:0]       base_s1;
	logic signed [17:0]       dval_s1;
	logic [POS_W-1:0]         span_s1;

	logic                     vld_s2;
	fe_item_t                 item_s2;

	assign adv        = !(vld_s2 && q_stat.full);
	assign in_stall   = !adv;
	assign item_valid = vld_s2;
	assign item       = item_s2;

	always_comb begin
		a_u     = axis_value;
		mag_x   = a_u[AXIS_W-1] ? (~a_u + 16'd1) : a_u;
		d_full  = $signed({2'b00, cfg.bend_x, 1'b0}) - $signed({3'b000, cfg.dead_zone})
			- $signed({3'b000, FULL_SCALE});
		x2_m_x1 = $signed({3'b000, cfg.bend_x}) - $signed({3'b000, cfg.dead_zone});
		x_m_x1  = $signed({2'b00, mag_x}) - $signed({3'b000, cfg.dead_zone});
		xd_c    = $signed({1'b0, mag_x}) * d_full;
		if (mag_x < {1'b0, cfg.dead_zone}) begin
			zone_c = ZONE_DEAD;
		end else if (mag_x > {1'b0, FULL_SCALE}) begin
			zone_c = ZONE_OVER;
		end else if (!cfg.curve_mode && cfg.dead_zone == FULL_SCALE) begin
			zone_c = ZONE_FAULT;
		end else begin
			zone_c = ZONE_ACTIVE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1      <= a_u[AXIS_W-1];
			zone_s1     <= zone_c;
			bez_s1      <= cfg.curve_mode;
			degen_s1    <= (d_full == 18'sd0);
			xd_s1       <= xd_c;
			x2sq_s1     <= cfg.bend_x * cfg.bend_x;
			x1h_s1      <= cfg.dead_zone * FULL_SCALE;
			lin_prod_s1 <= cfg.max_level * x_m_x1[15:0];
			base_s1     <= (d_full == 18'sd0) ? x_m_x1 : x2_m_x1;
			dval_s1     <= (d_full == 18'sd0) ? $signed({x2_m_x1[16:0], 1'b0}) : d_full;
			span_s1     <= FULL_SCALE - cfg.dead_zone;

			item_s2.neg     <= neg_s1;
			item_s2.zone    <= zone_s1;
			item_s2.bez     <= bez_s1;
			item_s2.degen   <= degen_s1;
			item_s2.disc    <= $signed({5'b00000, x2sq_s1}) - $signed({5'b00000, x1h_s1})
				- xd_s1;
			item_s2.base    <= base_s1;
			item_s2.dval    <= dval_s1;
			item_s2.lin_num <= {lin_prod_s1, 8'h00} + {2'b00, lin_prod_s1, 6'h00};
			item_s2.lin_den <= DEN_W'(span_s1) << FRAC_BITS;
		end
	end

endmodule

/* hw/rtl/dzc_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Dead-zone response curve queue
// Short FIFO of classified samples between the front end and the back end.
// ---------------------------------------------------------------------------
module dzc_queue #(
	parameter int DEPTH = dzc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dzc_pkg::fe_item_t push_item,
	input  logic              pop,
	output dzc_pkg::fe_item_t pop_item,
	output dzc_pkg::q_stat_t  stat
);
	import dzc_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	fe_item_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* hw/rtl/dzc_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Dead-zone response curve back end
// Pipelined square root, divider and level evaluation for queued samples.
// ---------------------------------------------------------------------------
module dzc_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dzc_pkg::cfg_t                      cfg,
	input  dzc_pkg::q_stat_t                   q_stat,
	input  dzc_pkg::fe_item_t                  item,
	output logic                               pop,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [dzc_pkg::DRIVE_W-1:0] drive,
	output logic [dzc_pkg::ZONE_W-1:0]         zone_status
);
	import dzc_pkg::*;

	localparam int SQ_STAGES  = ROOT_W;
	localparam int DIV_STAGES = QUOT_W;

	typedef struct packed {
		logic               neg;
		zone_t              zone;
		logic               bez;
		logic               degen;
		logic               disc_neg;
		logic signed [17:0] base;
		logic signed [17:0] dval;
		logic [NUM_W-1:0]   lin_num;
		logic [DEN_W-1:0]   lin_den;
	} info_t;

	typedef struct packed {
		info_t             info;
		logic [31:0]       v;
		logic [17:0]       rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	typedef struct packed {
		logic              neg;
		zone_t             zone;
		logic              bez;
		logic              tzero;
		logic              tone;
		logic [QUOT_W-1:0] nlow;
		logic [DEN_W-1:0]  rem;
		logic [DEN_W-1:0]  den;
		logic [QUOT_W-1:0] q;
	} dv_t;

	logic adv;

	logic sq_vld_q [SQ_STAGES+1];
	sq_t  sq_q     [SQ_STAGES+1];
	sq_t  sq_d     [SQ_STAGES+1];
	logic dv_vld_q [DIV_STAGES+1];
	dv_t  dv_q     [DIV_STAGES+1];
	dv_t  dv_d     [DIV_STAGES+1];

	logic [19:0]        sq_rx;
	logic [19:0]        sq_trial;
	logic [DEN_W:0]     dv_rx;
	logic [DEN_W:0]     dv_sub;

	info_t              pinfo;
	logic signed [17:0] n_c;
	logic signed [17:0] d_c;
	logic [17:0]        un_c;
	logic [17:0]        ud_c;
	logic               fault_c;
	logic               tzero_c;
	logic               tone_c;
	logic [NUM_W-1:0]   num_c;
	logic [DEN_W-1:0]   den_c;

	logic [T_W-1:0]     t_c;
	logic [33:0]        pa_c;
	logic [33:0]        pb_c;
	logic [46:0]        la_c;
	logic [48:0]        lb_c;
	logic [49:0]        lvl_c;
	logic [58:0]        prod_c;
	logic [18:0]        mag_c;
	logic [16:0]        sat_c;
	logic [17:0]        dmag_c;

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic               neg_s1, neg_s2, neg_s3, neg_s4;
	zone_t              zone_s1, zone_s2, zone_s3, zone_s4;
	logic               bez_s1, bez_s2, bez_s3, bez_s4;
	logic [QUOT_W-1:0]  lin_q_s1, lin_q_s2, lin_q_s3, lin_q_s4;
	logic [30:0]        pa_s1;
	logic [32:0]        pb_s1;
	logic [46:0]        la_s2;
	logic [48:0]        lb_s2;
	logic [49:0]        lvl_s3;
	logic [18:0]        bmag_s4;

	logic                       out_vld_q;
	logic signed [DRIVE_W-1:0]  drive_q;
	zone_t                      zone_q;

	assign adv         = !(out_vld_q && out_stall);
	assign pop         = adv && !q_stat.empty;
	assign out_valid   = out_vld_q;
	assign drive       = drive_q;
	assign zone_status = zone_q;

	// square root, one result bit per stage
	always_comb begin
		sq_rx    = '0;
		sq_trial = '0;
		sq_d[0].info.neg      = item.neg;
		sq_d[0].info.zone     = item.zone;
		sq_d[0].info.bez      = item.bez;
		sq_d[0].info.degen    = item.degen;
		sq_d[0].info.disc_neg = item.disc[DISC_W-1];
		sq_d[0].info.base     = item.base;
		sq_d[0].info.dval     = item.dval;
		sq_d[0].info.lin_num  = item.lin_num;
		sq_d[0].info.lin_den  = item.lin_den;
		sq_d[0].v             = item.disc[DISC_W-1] ? 32'h0 : item.disc[31:0];
		sq_d[0].rem           = '0;
		sq_d[0].root          = '0;
		for (int k = 0; k < SQ_STAGES; k++) begin
			sq_rx    = {sq_q[k].rem, sq_q[k].v[31:30]};
			sq_trial = {2'b00, sq_q[k].root, 2'b01};
			sq_d[k+1].info = sq_q[k].info;
			sq_d[k+1].v    = {sq_q[k].v[29:0], 2'b00};
			if (sq_rx >= sq_trial) begin
				sq_d[k+1].rem  = 18'(sq_rx - sq_trial);
				sq_d[k+1].root = {sq_q[k].root[ROOT_W-2:0], 1'b1};
			end else begin
				sq_d[k+1].rem  = 18'(sq_rx);
				sq_d[k+1].root = {sq_q[k].root[ROOT_W-2:0], 1'b0};
			end
		end
	end

	// form the dividend and divisor, then one quotient bit per stage
	always_comb begin
		pinfo   = sq_q[SQ_STAGES].info;
		n_c     = pinfo.degen ? pinfo.base
			: pinfo.base - $signed({2'b00, sq_q[SQ_STAGES].root});
		d_c     = pinfo.dval;
		fault_c = pinfo.bez && ((!pinfo.degen && pinfo.disc_neg) || d_c == 18'sd0);
		tzero_c = (n_c == 18'sd0) || (n_c[17] != d_c[17]);
		un_c    = n_c[17] ? (~n_c + 18'd1) : n_c;
		ud_c    = d_c[17] ? (~d_c + 18'd1) : d_c;
		tone_c  = {1'b0, un_c} >= {ud_c, 1'b0};
		if (pinfo.zone != ZONE_ACTIVE || (pinfo.bez && (fault_c || tzero_c || tone_c))) begin
			num_c = '0;
			den_c = DEN_W'(1);
		end else if (pinfo.bez) begin
			num_c = NUM_W'({un_c, 16'h0000}) + NUM_W'(ud_c >> 1);
			den_c = DEN_W'(ud_c);
		end else begin
			num_c = pinfo.lin_num + NUM_W'(pinfo.lin_den >> 1);
			den_c = pinfo.lin_den;
		end
		dv_d[0].neg   = pinfo.neg;
		dv_d[0].zone  = (pinfo.zone == ZONE_ACTIVE && fault_c) ? ZONE_FAULT : pinfo.zone;
		dv_d[0].bez   = pinfo.bez;
		dv_d[0].tzero = tzero_c;
		dv_d[0].tone  = tone_c;
		dv_d[0].nlow  = num_c[QUOT_W-1:0];
		dv_d[0].rem   = DEN_W'(num_c[NUM_W-1:QUOT_W]);
		dv_d[0].den   = den_c;
		dv_d[0].q     = '0;

		dv_rx  = '0;
		dv_sub = '0;
		for (int k = 0; k < DIV_STAGES; k++) begin
			dv_rx  = {dv_q[k].rem, dv_q[k].nlow[QUOT_W-1]};
			dv_sub = {1'b0, dv_q[k].den};
			dv_d[k+1]      = dv_q[k];
			dv_d[k+1].nlow = {dv_q[k].nlow[QUOT_W-2:0], 1'b0};
			if (dv_rx >= dv_sub) begin
				dv_d[k+1].rem = DEN_W'(dv_rx - dv_sub);
				dv_d[k+1].q   = {dv_q[k].q[QUOT_W-2:0], 1'b1};
			end else begin
				dv_d[k+1].rem = DEN_W'(dv_rx);
				dv_d[k+1].q   = {dv_q[k].q[QUOT_W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (dv_q[DIV_STAGES].tzero) begin
			t_c = '0;
		end else if (dv_q[DIV_STAGES].tone || dv_q[DIV_STAGES].q > {1'b0, T_ONE}) begin
			t_c = T_ONE;
		end else begin
			t_c = dv_q[DIV_STAGES].q[T_W-1:0];
		end
		pa_c   = (T_ONE - t_c) * t_c;
		pb_c   = t_c * t_c;
		la_c   = pa_s1 * cfg.bend_y;
		lb_c   = pb_s1 * cfg.max_level;
		lvl_c  = {2'b00, la_s2, 1'b0} + {1'b0, lb_s2};
		prod_c = {1'b0, lvl_s3, 8'h00} + {3'b000, lvl_s3, 6'h00} + (59'd1 << (LVL_SHIFT - 1));
		if (zone_s4 != ZONE_ACTIVE) begin
			mag_c = '0;
		end else if (bez_s4) begin
			mag_c = bmag_s4;
		end else begin
			mag_c = {1'b0, lin_q_s4};
		end
		sat_c  = (mag_c > {2'b00, DRIVE_MAX}) ? DRIVE_MAX : mag_c[16:0];
		dmag_c = {1'b0, sat_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= SQ_STAGES; k++) begin
				sq_vld_q[k] <= 1'b0;
			end
			for (int k = 0; k <= DIV_STAGES; k++) begin
				dv_vld_q[k] <= 1'b0;
			end
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			sq_vld_q[0] <= !q_stat.empty;
			for (int k = 0; k < SQ_STAGES; k++) begin
				sq_vld_q[k+1] <= sq_vld_q[k];
			end
			dv_vld_q[0] <= sq_vld_q[SQ_STAGES];
			for (int k = 0; k < DIV_STAGES; k++) begin
				dv_vld_q[k+1] <= dv_vld_q[k];
			end
			vld_s1    <= dv_vld_q[DIV_STAGES];
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			out_vld_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k <= SQ_STAGES; k++) begin
				sq_q[k] <= sq_d[k];
			end
			for (int k = 0; k <= DIV_STAGES; k++) begin
				dv_q[k] <= dv_d[k];
			end
			neg_s1   <= dv_q[DIV_STAGES].neg;
			zone_s1  <= dv_q[DIV_STAGES].zone;
			bez_s1   <= dv_q[DIV_STAGES].bez;
			lin_q_s1 <= dv_q[DIV_STAGES].q;
			pa_s1    <= pa_c[30:0];
			pb_s1    <= pb_c[32:0];

			neg_s2   <= neg_s1;
			zone_s2  <= zone_s1;
			bez_s2   <= bez_s1;
			lin_q_s2 <= lin_q_s1;
			la_s2    <= la_c;
			lb_s2    <= lb_c;

			neg_s3   <= neg_s2;
			zone_s3  <= zone_s2;
			bez_s3   <= bez_s2;
			lin_q_s3 <= lin_q_s2;
			lvl_s3   <= lvl_c;

			neg_s4   <= neg_s3;
			zone_s4  <= zone_s3;
			bez_s4   <= bez_s3;
			lin_q_s4 <= lin_q_s3;
			bmag_s4  <= prod_c[LVL_SHIFT +: 19];

			drive_q  <= neg_s4 ? $signed(~dmag_c + 18'd1) : $signed(dmag_c);
			zone_q   <= zone_s4;
		end
	end

endmodule

/* hw/rtl/axis_deadzone_response_curve_top.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// Joystick axis dead zone and response curve
// Maps signed axis samples to signed drive values through a dead zone, an
// over-range cut and a linear or quadratic Bezier response curve.
// ---------------------------------------------------------------------------
// Input channel: in_valid / in_stall with axis_value (signed Q8 percent).
// Output channel: out_valid / out_stall with drive and zone_status.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 curve mode,
// 1 dead zone, 2 bend x, 3 bend y, 4 max level); higher indexes are ignored.
// Write registers only while no sample is in flight.
// Throughput: one sample per clock cycle unless out_stall holds a result,
// set by the fully pipelined square root (16 result bits) and divider (18
// quotient bits) in the back end. From acceptance to out_valid a sample
// passes two front-end stages, one queue slot, 17 root stages, 19 divider
// stages, four level stages and the output register.
// When out_stall holds a result, the back end holds; the four-entry queue
// keeps the front end running until it fills, then in_stall rises.
// Reset clears all pipelines and the queue and loads the register defaults
// (linear mode, no dead zone, bend 12800/12800, max level 25600).
// ---------------------------------------------------------------------------
module axis_deadzone_response_curve_top #(
	parameter int QUEUE_DEPTH = dzc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [dzc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [dzc_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [dzc_pkg::AXIS_W-1:0]     axis_value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [dzc_pkg::DRIVE_W-1:0]    drive,
	output logic [dzc_pkg::ZONE_W-1:0]            zone_status
);
	import dzc_pkg::*;

	cfg_t     cfg_q;
	logic     fe_valid;
	fe_item_t fe_item;
	fe_item_t q_item;
	q_stat_t  q_stat;
	logic     q_push;
	logic     q_pop;

	assign q_push = fe_valid && !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.curve_mode <= 1'b0;
			cfg_q.dead_zone  <= RST_DEAD_ZONE;
			cfg_q.bend_x     <= RST_BEND_X;
			cfg_q.bend_y     <= RST_BEND_Y;
			cfg_q.max_level  <= RST_MAX_LEVEL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CURVE_MODE: cfg_q.curve_mode <= cfg_data[0];
				REG_DEAD_ZONE:  cfg_q.dead_zone  <= cfg_data[POS_W-1:0];
				REG_BEND_X:     cfg_q.bend_x     <= cfg_data[POS_W-1:0];
				REG_BEND_Y:     cfg_q.bend_y     <= cfg_data;
				REG_MAX_LEVEL:  cfg_q.max_level  <= cfg_data;
				default: ;
			endcase
		end
	end

	dzc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.axis_value (axis_value),
		.item_valid (fe_valid),
		.item       (fe_item),
		.q_stat     (q_stat)
	);

	dzc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (fe_item),
		.pop       (q_pop),
		.pop_item  (q_item),
		.stat      (q_stat)
	);

	dzc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_stat      (q_stat),
		.item        (q_item),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.drive       (drive),
		.zone_status (zone_status)
	);

	`ASSERT_PROP(a_zero_drive_off_curve, clk, arst_n, out_valid && zone_status != ZONE_ACTIVE |-> drive == '0, "drive nonzero outside active zone")
	`ASSERT_PROP(a_stall_needs_full_queue, clk, arst_n, in_stall |-> q_stat.full, "input stalled with room in queue")
	`ASSERT_NEVER(a_queue_flags, clk, arst_n, q_stat.full && q_stat.empty, "queue full and empty at once")

endmodule
